// File: design/tpce_pkg.sv
// Package: shared constants and types for the passive connection engine.
`default_nettype none
package tpce_pkg;
	localparam int SLOTS_DEF = 16;
	localparam int MAX_RESEND = 16;
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

	localparam logic [1:0] ST_CLOSED = 2'd0;
	localparam logic [1:0] ST_SYNRCVD = 2'd1;
	localparam logic [1:0] ST_ESTAB = 2'd2;
	localparam logic [1:0] ST_LASTACK = 2'd3;

	localparam logic [3:0] ACT_NONE = 4'd0;
	localparam logic [3:0] ACT_DROP = 4'd1;
	localparam logic [3:0] ACT_SYNACK = 4'd2;
	localparam logic [3:0] ACT_ACK = 4'd3;
	localparam logic [3:0] ACT_FINACK = 4'd4;
	localparam logic [3:0] ACT_RESET = 4'd5;
	localparam logic [3:0] ACT_DELIVER = 4'd6;
	localparam logic [3:0] ACT_RESYN = 4'd7;
	localparam logic [3:0] ACT_REACK = 4'd8;
	localparam logic [3:0] ACT_DONE = 4'd9;

	localparam logic [2:0] REG_RTO = 3'd0;
	localparam logic [2:0] REG_RETRY = 3'd1;
	localparam logic [2:0] REG_CWND = 3'd2;
	localparam logic [2:0] REG_SSTH = 3'd3;
	localparam logic [2:0] REG_SEED = 3'd4;

	// one connection slot record
	typedef struct packed {
		logic [31:0] laddr;
		logic [31:0] raddr;
		logic [15:0] lport;
		logic [15:0] rport;
		logic [31:0] rnext;
		logic [31:0] snext;
		logic [31:0] ltime;
		logic [7:0] retry;
		logic [15:0] rto;
		logic [15:0] cwnd;
		logic [15:0] ssth;
	} slot_rec_t;

	// one result beat
	typedef struct packed {
		logic [3:0] action;
		logic [3:0] slot;
		logic [31:0] laddr;
		logic [31:0] raddr;
		logic [15:0] lport;
		logic [15:0] rport;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] dlen;
	} result_t;

	function automatic logic [31:0] lfsr_step(input logic [31:0] v);
		logic [31:0] w;
		w = (v == 32'd0) ? 32'd1 : v;
		return w[0] ? ((w >> 1) ^ LFSR_MASK) : (w >> 1);
	endfunction
endpackage
`default_nettype wire

// File: design/tcp_passive_connection_engine.sv
// Top level: slot table, sequencer and result register of the connection engine.
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | func .. port_listening
//  out     | out_valid / out_stall| action .. last
//  cfg     | cfg_we               | cfg_index, cfg_data
// A segment keeps in_stall high while the sequencer walks the slots for a port
// match, searches a free slot when a SYN finds none, reads the chosen slot, decides
// and emits its result beats; an invalid segment goes straight to its drop beat. A
// tick walks the slots for resends. A beat under out_stall holds the sequencer
// where it loads a beat; a new item is taken while the last beat still waits.
// Reset clears all slot states (flip-flops), the rest of the table needs none.
`default_nettype none
module tcp_passive_connection_engine #(
	parameter int SLOTS = tpce_pkg::SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic func,
	input wire logic [31:0] now_seconds,
	input wire logic [31:0] remote_addr,
	input wire logic [31:0] local_addr,
	input wire logic [15:0] remote_port,
	input wire logic [15:0] local_port,
	input wire logic [31:0] seg_seq,
	input wire logic [31:0] seg_ack,
	input wire logic [7:0] tcp_flags,
	input wire logic [15:0] payload_length,
	input wire logic segment_ok,
	input wire logic port_listening,
	output logic out_valid,
	input wire logic out_stall,
	output logic [3:0] action,
	output logic [3:0] slot,
	output logic [31:0] out_local_addr,
	output logic [31:0] out_remote_addr,
	output logic [15:0] out_local_port,
	output logic [15:0] out_remote_port,
	output logic [31:0] seq_out,
	output logic [31:0] ack_out,
	output logic [15:0] deliver_length,
	output logic last,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FIND = 4'd1;
	localparam logic [3:0] S_FREE = 4'd2;
	localparam logic [3:0] S_RD = 4'd3;
	localparam logic [3:0] S_SEG = 4'd4;
	localparam logic [3:0] S_EMIT = 4'd5;
	localparam logic [3:0] S_TRD = 4'd6;
	localparam logic [3:0] S_TCHK = 4'd7;
	localparam logic [3:0] S_TEMIT = 4'd8;

	// configuration
	logic [7:0] rto_init_q, retry_lim_q;
	logic [15:0] cwnd_init_q, ssth_init_q;
	logic [31:0] lfsr_q;

	// slot table
	logic [1:0] st_q [SLOTS];
	tpce_pkg::slot_rec_t mem [SLOTS];
	tpce_pkg::slot_rec_t rd_q;
	logic [SW-1:0] raddr;
	logic we;
	logic [SW-1:0] waddr;
	tpce_pkg::slot_rec_t wdata;
	logic st_we;
	logic [1:0] st_wd;

	// item and control
	logic [3:0] fsm_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] c_q;
	logic found_q;
	logic free_q, lis_q;
	logic [31:0] now_q, ra_q, la_q, seq_q, ack_q;
	logic [15:0] rp_q, lp_q, len_q;
	logic [7:0] fl_q;
	logic [4:0] nres_q;
	// queued segment results (up to four), shifted out
	tpce_pkg::result_t qr_q [4];
	logic [2:0] qn_q;
	tpce_pkg::result_t ob_q;
	logic ob_last_q, ob_v_q;

	// segment decision
	tpce_pkg::result_t r0, r1, rz, rst_r;
	tpce_pkg::slot_rec_t nrec;
	logic [1:0] nst;
	logic [1:0] nres;
	logic nwe;
	logic [31:0] isn;
	logic [31:0] rst_ack;
	logic [1:0] cst;
	logic [31:0] rn2;
	logic lfsr_adv;
	logic fin_add;
	tpce_pkg::result_t fa, fb;
	tpce_pkg::result_t sq_c [4];
	logic [2:0] sq_n;

	// tick compare unit
	tpce_pkg::slot_rec_t trec;
	tpce_pkg::result_t t_beat;
	logic t_live, t_due, t_close, t_send;

	// result register load
	logic ob_load, ob_last_d;
	tpce_pkg::result_t ob_d;

	wire [SW-1:0] idx_lo = idx_q[SW-1:0];
	wire [SW-1:0] prev_idx = SW'(idx_q - CW'(1));
	wire idx_end = (idx_q == CW'(SLOTS));
	wire ob_free = !ob_v_q || !out_stall;
	wire match_prev = (idx_q != '0) && !found_q &&
		(st_q[prev_idx] != tpce_pkg::ST_CLOSED) && (rd_q.lport == lp_q) && (rd_q.rport == rp_q);

	assign in_stall = (fsm_q != S_IDLE);
	assign out_valid = ob_v_q;
	assign action = ob_q.action;
	assign slot = ob_q.slot;
	assign out_local_addr = ob_q.laddr;
	assign out_remote_addr = ob_q.raddr;
	assign out_local_port = ob_q.lport;
	assign out_remote_port = ob_q.rport;
	assign seq_out = ob_q.seq;
	assign ack_out = ob_q.ack;
	assign deliver_length = ob_q.dlen;
	assign last = ob_last_q;

	// memory read and write
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// segment decision logic on the read slot record
	always_comb begin
		r0 = '0; r1 = '0; rz = '0;
		nrec = rd_q; nst = st_q[c_q]; nres = 2'd1; nwe = 1'b0;
		isn = tpce_pkg::lfsr_step(lfsr_q);
		cst = st_q[c_q];
		rn2 = rd_q.rnext;
		rst_ack = seq_q + 32'(len_q) + 32'(fl_q[1]) + 32'(fl_q[0]);
		rst_r = '0;
		rst_r.action = tpce_pkg::ACT_RESET;
		rst_r.laddr = la_q; rst_r.raddr = ra_q; rst_r.lport = lp_q; rst_r.rport = rp_q;
		rst_r.seq = fl_q[4] ? ack_q : 32'd0;
		rst_r.ack = fl_q[4] ? 32'd0 : rst_ack;
		rz.laddr = la_q; rz.raddr = ra_q; rz.lport = lp_q; rz.rport = rp_q;
		rz.slot = 4'(c_q);
		if (found_q && fl_q[2]) begin
			r0.slot = 4'(c_q);
			if (seq_q == rd_q.rnext) begin
				r0.action = tpce_pkg::ACT_NONE;
				nst = tpce_pkg::ST_CLOSED;
			end else
				r0.action = tpce_pkg::ACT_DROP;
		end else if (fl_q[1]) begin
			if (found_q) begin
				r0.action = tpce_pkg::ACT_DROP;
				r0.slot = 4'(c_q);
			end else if (!lis_q || !free_q) begin
				r0 = rst_r;
			end else begin
				nst = tpce_pkg::ST_SYNRCVD;
				nwe = 1'b1;
				nrec.laddr = la_q; nrec.raddr = ra_q;
				nrec.lport = lp_q; nrec.rport = rp_q;
				nrec.rnext = seq_q + 32'd1;
				nrec.snext = isn;
				nrec.ltime = now_q;
				nrec.retry = 8'd0;
				nrec.rto = 16'(rto_init_q);
				nrec.cwnd = cwnd_init_q;
				nrec.ssth = ssth_init_q;
				r0 = rz;
				r0.action = tpce_pkg::ACT_SYNACK;
				r0.seq = isn; r0.ack = seq_q + 32'd1;
			end
		end else if (!found_q) begin
			r0 = rst_r;
		end else begin
			nres = 2'd0;
			nwe = 1'b1;
			if (cst == tpce_pkg::ST_SYNRCVD && fl_q[4]) begin
				if (ack_q == rd_q.snext + 32'd1) begin
					cst = tpce_pkg::ST_ESTAB;
					nrec.snext = ack_q;
					nrec.ltime = now_q;
					nrec.retry = 8'd0;
				end
			end else if (cst == tpce_pkg::ST_ESTAB && len_q != 16'd0) begin
				if (seq_q == rd_q.rnext) begin
					rn2 = rd_q.rnext + 32'(len_q);
					nrec.rnext = rn2;
					if (rd_q.cwnd < rd_q.ssth) nrec.cwnd = rd_q.cwnd + 16'd1;
					nrec.ltime = now_q;
					nrec.retry = 8'd0;
					r0 = rz; r0.action = tpce_pkg::ACT_DELIVER; r0.dlen = len_q;
					r1 = rz; r1.action = tpce_pkg::ACT_ACK;
					r1.seq = rd_q.snext; r1.ack = rn2;
					nres = 2'd2;
				end
			end
			if (fl_q[0]) begin
				if (cst == tpce_pkg::ST_ESTAB || cst == tpce_pkg::ST_SYNRCVD) begin
					nrec.rnext = seq_q + 32'd1;
					cst = tpce_pkg::ST_LASTACK;
				end
			end else if (cst == tpce_pkg::ST_LASTACK && fl_q[4])
				cst = tpce_pkg::ST_CLOSED;
			nst = cst;
			if (nres == 2'd0) begin
				r0 = '0; r0.slot = 4'(c_q);
				nres = 2'd1;
			end
		end
		lfsr_adv = (fsm_q == S_SEG) && fl_q[1] && !found_q && lis_q && free_q;
	end

	// FIN replies follow any data replies; build the result queue
	always_comb begin
		fin_add = found_q && !fl_q[2] && !fl_q[1] && fl_q[0] &&
			(st_q[c_q] == tpce_pkg::ST_ESTAB || st_q[c_q] == tpce_pkg::ST_SYNRCVD);
		fa = rz; fa.action = tpce_pkg::ACT_ACK;
		fa.seq = nrec.snext; fa.ack = seq_q + 32'd1;
		fb = fa; fb.action = tpce_pkg::ACT_FINACK;
		sq_c[0] = r0; sq_c[1] = r1; sq_c[2] = '0; sq_c[3] = '0;
		sq_n = {1'b0, nres};
		if (fin_add) begin
			if (nres == 2'd2) begin
				sq_c[2] = fa; sq_c[3] = fb; sq_n = 3'd4;
			end else begin
				sq_c[0] = fa; sq_c[1] = fb; sq_n = 3'd2;
			end
		end
	end

	// tick compare unit
	always_comb begin
		t_live = (st_q[c_q] == tpce_pkg::ST_SYNRCVD) || (st_q[c_q] == tpce_pkg::ST_ESTAB);
		t_due = (now_q - rd_q.ltime) >= 32'(rd_q.rto);
		t_close = t_live && t_due && (rd_q.retry >= retry_lim_q);
		t_send = t_live && t_due && !t_close && (nres_q < 5'(tpce_pkg::MAX_RESEND));
		trec = rd_q;
		trec.ssth = (rd_q.cwnd > 16'd1) ? (rd_q.cwnd >> 1) : 16'd2;
		trec.cwnd = 16'd1;
		trec.ltime = now_q;
		if (rd_q.retry != 8'hFF) trec.retry = rd_q.retry + 8'd1;
		trec.rto = (rd_q.rto > 16'd32767) ? 16'hFFFF : {rd_q.rto[14:0], 1'b0};
		t_beat = '0;
		t_beat.action = (st_q[c_q] == tpce_pkg::ST_SYNRCVD) ?
			tpce_pkg::ACT_RESYN : tpce_pkg::ACT_REACK;
		t_beat.slot = 4'(c_q);
		t_beat.laddr = rd_q.laddr; t_beat.raddr = rd_q.raddr;
		t_beat.lport = rd_q.lport; t_beat.rport = rd_q.rport;
		t_beat.seq = rd_q.snext; t_beat.ack = rd_q.rnext;
	end

	// table write and read address
	always_comb begin
		raddr = idx_lo;
		we = 1'b0; waddr = c_q; wdata = nrec;
		st_we = 1'b0; st_wd = nst;
		if (fsm_q == S_SEG) begin
			we = nwe;
			st_we = nwe || (found_q && fl_q[2]);
		end
		if (fsm_q == S_TCHK && t_send && ob_free) begin
			we = 1'b1; wdata = trec;
		end
		if (fsm_q == S_TCHK && t_close) begin
			st_we = 1'b1; st_wd = tpce_pkg::ST_CLOSED;
		end
		if (fsm_q == S_RD) raddr = c_q;
	end

	// pick the beat for the result register
	always_comb begin
		ob_load = 1'b0; ob_d = qr_q[0]; ob_last_d = 1'b0;
		case (fsm_q)
			S_EMIT: begin
				if (ob_free) begin
					ob_load = 1'b1; ob_last_d = (qn_q == 3'd1);
				end
			end
			S_TCHK: begin
				if (t_send && ob_free) begin
					ob_load = 1'b1; ob_d = t_beat;
				end
			end
			S_TEMIT: begin
				if (idx_q == CW'(SLOTS - 1) && ob_free) begin
					ob_load = 1'b1; ob_d = '0; ob_d.action = tpce_pkg::ACT_DONE;
					ob_last_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= S_IDLE; idx_q <= '0; c_q <= '0; found_q <= 1'b0; free_q <= 1'b0;
			ob_v_q <= 1'b0; ob_last_q <= 1'b0; ob_q <= '0; qn_q <= '0; nres_q <= '0;
			rto_init_q <= 8'd1; retry_lim_q <= 8'd5;
			cwnd_init_q <= 16'd1; ssth_init_q <= 16'd64; lfsr_q <= 32'd1;
			for (int i = 0; i < SLOTS; i++) st_q[i] <= tpce_pkg::ST_CLOSED;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tpce_pkg::REG_RTO: rto_init_q <= cfg_data[7:0];
					tpce_pkg::REG_RETRY: retry_lim_q <= cfg_data[7:0];
					tpce_pkg::REG_CWND: cwnd_init_q <= cfg_data[15:0];
					tpce_pkg::REG_SSTH: ssth_init_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			// seed write reloads the generator, a new connection advances it
			if (cfg_we && cfg_index == tpce_pkg::REG_SEED) lfsr_q <= cfg_data;
			else if (lfsr_adv) lfsr_q <= isn;
			if (st_we) st_q[c_q] <= st_wd;
			// load a beat, or drop the one just taken
			if (ob_load) begin
				ob_q <= ob_d; ob_last_q <= ob_last_d; ob_v_q <= 1'b1;
			end else if (!out_stall) ob_v_q <= 1'b0;
			case (fsm_q)
				S_IDLE: begin
					if (in_valid) begin
						now_q <= now_seconds; ra_q <= remote_addr;
						la_q <= local_addr; rp_q <= remote_port; lp_q <= local_port;
						seq_q <= seg_seq; ack_q <= seg_ack; fl_q <= tcp_flags;
						len_q <= payload_length; lis_q <= port_listening;
						idx_q <= '0; found_q <= 1'b0; free_q <= 1'b0; c_q <= '0; nres_q <= '0;
						if (func) fsm_q <= S_TRD;
						else if (!segment_ok) begin
							qr_q[0] <= '{action: tpce_pkg::ACT_DROP, default: '0};
							qn_q <= 3'd1; fsm_q <= S_EMIT;
						end else fsm_q <= S_FIND;
					end
				end
				// walk port match, one slot a cycle on the registered read
				S_FIND: begin
					if (match_prev) begin
						found_q <= 1'b1; c_q <= prev_idx;
					end
					if (idx_end) begin
						idx_q <= '0;
						fsm_q <= (!found_q && !match_prev && fl_q[1]) ? S_FREE : S_RD;
					end else idx_q <= idx_q + CW'(1);
				end
				// search a free slot
				S_FREE: begin
					if (!free_q && st_q[idx_lo] == tpce_pkg::ST_CLOSED) begin
						free_q <= 1'b1; c_q <= idx_lo;
					end
					if (idx_q == CW'(SLOTS - 1)) fsm_q <= S_RD;
					else idx_q <= idx_q + CW'(1);
				end
				S_RD: fsm_q <= S_SEG;
				S_SEG: begin
					for (int k = 0; k < 4; k++) qr_q[k] <= sq_c[k];
					qn_q <= sq_n;
					fsm_q <= S_EMIT;
				end
				// advance the queue one beat at a time
				S_EMIT: begin
					if (ob_free) begin
						qr_q[0] <= qr_q[1]; qr_q[1] <= qr_q[2]; qr_q[2] <= qr_q[3];
						qn_q <= qn_q - 3'd1;
						if (qn_q == 3'd1) fsm_q <= S_IDLE;
					end
				end
				S_TRD: begin
					c_q <= idx_lo; fsm_q <= S_TCHK;
				end
				S_TCHK: begin
					if (t_send) begin
						if (ob_free) begin
							nres_q <= nres_q + 5'd1;
							fsm_q <= S_TEMIT;
						end
					end else fsm_q <= S_TEMIT;
				end
				S_TEMIT: begin
					if (idx_q == CW'(SLOTS - 1)) begin
						if (ob_free) fsm_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + CW'(1); fsm_q <= S_TRD;
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	// assertions
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q != S_IDLE) |-> in_stall) else $error("busy but ready");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("beat lost");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(action) && $stable(seq_out) && $stable(last)))
		else $error("stalled beat changed");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == tpce_pkg::ACT_DONE) |-> last)
		else $error("scan done not last");
endmodule
`default_nettype wire

// File: test/testbench.sv
// Testbench: queue-fed driver, clocked monitor and predictor for the connection engine.
`default_nettype none
module testbench;
	localparam int NSLOT = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic func;
		logic [31:0] now;
		logic [31:0] raddr;
		logic [31:0] laddr;
		logic [15:0] rport;
		logic [15:0] lport;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [7:0] flags;
		logic [15:0] len;
		logic ok;
		logic listen;
	} seg_item_t;

	typedef struct packed {
		tpce_pkg::result_t r;
		logic last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	seg_item_t drv = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] action, slot;
	logic [31:0] out_local_addr, out_remote_addr, seq_out, ack_out;
	logic [15:0] out_local_port, out_remote_port, deliver_length;
	logic last;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	tcp_passive_connection_engine dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.func(drv.func), .now_seconds(drv.now), .remote_addr(drv.raddr),
		.local_addr(drv.laddr), .remote_port(drv.rport), .local_port(drv.lport),
		.seg_seq(drv.seq), .seg_ack(drv.ack), .tcp_flags(drv.flags),
		.payload_length(drv.len), .segment_ok(drv.ok), .port_listening(drv.listen),
		.out_valid(out_valid), .out_stall(out_stall), .action(action), .slot(slot),
		.out_local_addr(out_local_addr), .out_remote_addr(out_remote_addr),
		.out_local_port(out_local_port), .out_remote_port(out_remote_port),
		.seq_out(seq_out), .ack_out(ack_out), .deliver_length(deliver_length),
		.last(last), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [1:0] m_st [NSLOT];
	tpce_pkg::slot_rec_t m_slot [NSLOT];
	logic [31:0] m_lfsr;
	logic [7:0] m_rto0, m_retry_lim;
	logic [15:0] m_cwnd0, m_ssth0;

	seg_item_t pending_items[$];
	beat_t expected_beats[$];
	int errors = 0;
	int beats_seen = 0;
	int items_sent = 0;
	int send_idle = 32, recv_idle = 60;
	bit hold_send = 1'b0;
	bit in_taken = 1'b0;
	int quiet_cycles = 0;
	int ticks_sent = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch beat %0d %s: got %h want %h", beats_seen, what, got, want);
		errors++;
	endtask

	function automatic tpce_pkg::result_t mk(input logic [3:0] a, input logic [3:0] s);
		tpce_pkg::result_t r;
		r = '0;
		r.action = a;
		r.slot = s;
		return r;
	endfunction

	function automatic tpce_pkg::result_t mk_full(input logic [3:0] a, input int c,
			input seg_item_t it, input logic [31:0] sq, input logic [31:0] ak,
			input logic [15:0] dl);
		tpce_pkg::result_t r;
		r = mk(a, c[3:0]);
		r.laddr = it.laddr;
		r.raddr = it.raddr;
		r.lport = it.lport;
		r.rport = it.rport;
		r.seq = sq;
		r.ack = ak;
		r.dlen = dl;
		return r;
	endfunction

	function automatic tpce_pkg::result_t reset_reply(input seg_item_t it);
		tpce_pkg::result_t r;
		logic [31:0] a;
		a = it.seq + 32'(it.len) + 32'(it.flags[1]) + 32'(it.flags[0]);
		if (it.flags[4]) r = mk_full(tpce_pkg::ACT_RESET, 0, it, it.ack, 32'd0, 16'd0);
		else r = mk_full(tpce_pkg::ACT_RESET, 0, it, 32'd0, a, 16'd0);
		return r;
	endfunction

	// work out the result beats of one item and advance the shadow table
	task automatic predict_item(input seg_item_t it);
		tpce_pkg::result_t rs[$];
		int c, n;
		logic [1:0] st;
		c = -1;
		if (it.func) begin
			n = 0;
			for (int i = 0; i < NSLOT; i++) begin
				st = m_st[i];
				if (st != tpce_pkg::ST_SYNRCVD && st != tpce_pkg::ST_ESTAB) continue;
				if ((it.now - m_slot[i].ltime) < 32'(m_slot[i].rto)) continue;
				if (m_slot[i].retry >= m_retry_lim) begin
					m_st[i] = tpce_pkg::ST_CLOSED;
					continue;
				end
				if (n >= tpce_pkg::MAX_RESEND) continue;
				m_slot[i].ssth = (m_slot[i].cwnd > 16'd1) ? (m_slot[i].cwnd >> 1) : 16'd2;
				m_slot[i].cwnd = 16'd1;
				rs.push_back('{action: (st == tpce_pkg::ST_SYNRCVD) ?
						tpce_pkg::ACT_RESYN : tpce_pkg::ACT_REACK,
					slot: i[3:0], laddr: m_slot[i].laddr, raddr: m_slot[i].raddr,
					lport: m_slot[i].lport, rport: m_slot[i].rport,
					seq: m_slot[i].snext, ack: m_slot[i].rnext, dlen: 16'd0});
				n++;
				m_slot[i].ltime = it.now;
				if (m_slot[i].retry != 8'd255) m_slot[i].retry++;
				m_slot[i].rto = (m_slot[i].rto > 16'd32767) ? 16'hFFFF :
					{m_slot[i].rto[14:0], 1'b0};
			end
			rs.push_back(mk(tpce_pkg::ACT_DONE, 4'd0));
		end else if (!it.ok) begin
			rs.push_back(mk(tpce_pkg::ACT_DROP, 4'd0));
		end else begin
			for (int i = 0; i < NSLOT; i++)
				if (c < 0 && m_st[i] != tpce_pkg::ST_CLOSED && m_slot[i].lport == it.lport &&
						m_slot[i].rport == it.rport)
					c = i;
			if (c >= 0 && it.flags[2]) begin
				if (it.seq == m_slot[c].rnext) begin
					m_st[c] = tpce_pkg::ST_CLOSED;
					rs.push_back(mk(tpce_pkg::ACT_NONE, c[3:0]));
				end else rs.push_back(mk(tpce_pkg::ACT_DROP, c[3:0]));
			end else if (it.flags[1]) begin
				if (c >= 0) rs.push_back(mk(tpce_pkg::ACT_DROP, c[3:0]));
				else if (!it.listen) rs.push_back(reset_reply(it));
				else begin
					for (int i = 0; i < NSLOT; i++)
						if (c < 0 && m_st[i] == tpce_pkg::ST_CLOSED) c = i;
					if (c < 0) rs.push_back(reset_reply(it));
					else begin
						m_lfsr = (m_lfsr == 32'd0) ? 32'd1 : m_lfsr;
						m_lfsr = m_lfsr[0] ? ((m_lfsr >> 1) ^ tpce_pkg::LFSR_MASK) : (m_lfsr >> 1);
						m_st[c] = tpce_pkg::ST_SYNRCVD;
						m_slot[c] = '{laddr: it.laddr, raddr: it.raddr, lport: it.lport,
							rport: it.rport, rnext: it.seq + 32'd1, snext: m_lfsr,
							ltime: it.now, retry: 8'd0, rto: 16'(m_rto0),
							cwnd: m_cwnd0, ssth: m_ssth0};
						rs.push_back(mk_full(tpce_pkg::ACT_SYNACK, c, it, m_slot[c].snext,
							m_slot[c].rnext, 16'd0));
					end
				end
			end else if (c < 0) begin
				rs.push_back(reset_reply(it));
			end else begin
				if (m_st[c] == tpce_pkg::ST_SYNRCVD && it.flags[4]) begin
					if (it.ack == m_slot[c].snext + 32'd1) begin
						m_st[c] = tpce_pkg::ST_ESTAB;
						m_slot[c].snext = it.ack;
						m_slot[c].ltime = it.now;
						m_slot[c].retry = 8'd0;
					end
				end else if (m_st[c] == tpce_pkg::ST_ESTAB && it.len != 16'd0) begin
					if (it.seq == m_slot[c].rnext) begin
						rs.push_back(mk_full(tpce_pkg::ACT_DELIVER, c, it, 32'd0, 32'd0, it.len));
						m_slot[c].rnext += 32'(it.len);
						if (m_slot[c].cwnd < m_slot[c].ssth) m_slot[c].cwnd++;
						rs.push_back(mk_full(tpce_pkg::ACT_ACK, c, it, m_slot[c].snext,
							m_slot[c].rnext, 16'd0));
						m_slot[c].ltime = it.now;
						m_slot[c].retry = 8'd0;
					end
				end
				if (it.flags[0]) begin
					if (m_st[c] == tpce_pkg::ST_ESTAB || m_st[c] == tpce_pkg::ST_SYNRCVD) begin
						m_slot[c].rnext = it.seq + 32'd1;
						rs.push_back(mk_full(tpce_pkg::ACT_ACK, c, it, m_slot[c].snext,
							m_slot[c].rnext, 16'd0));
						m_st[c] = tpce_pkg::ST_LASTACK;
						rs.push_back(mk_full(tpce_pkg::ACT_FINACK, c, it, m_slot[c].snext,
							m_slot[c].rnext, 16'd0));
					end
				end else if (m_st[c] == tpce_pkg::ST_LASTACK && it.flags[4]) begin
					m_st[c] = tpce_pkg::ST_CLOSED;
				end
				if (rs.size() == 0) rs.push_back(mk(tpce_pkg::ACT_NONE, c[3:0]));
			end
		end
		foreach (rs[k]) expected_beats.push_back('{r: rs[k], last: (k == rs.size() - 1)});
	endtask

	// driver: present the next pending item once the previous beat is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (!hold_send && pending_items.size() != 0 &&
						$urandom_range(99) >= send_idle) begin
					drv <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else in_valid <= 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// monitor: predict each taken input beat, compare every taken result beat
	always @(posedge clk) begin
		beat_t e;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_item(drv);
				items_sent++;
				in_taken = 1'b1;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (out_valid && !out_stall) begin
				beats_seen++;
				if (expected_beats.size() == 0) begin
					report("unexpected action", 32'(action), 32'd0);
				end else begin
					e = expected_beats.pop_front();
					if (action !== e.r.action) report("action", 32'(action), 32'(e.r.action));
					if (slot !== e.r.slot) report("slot", 32'(slot), 32'(e.r.slot));
					if (out_local_addr !== e.r.laddr) report("laddr", out_local_addr, e.r.laddr);
					if (out_remote_addr !== e.r.raddr)
						report("raddr", out_remote_addr, e.r.raddr);
					if (out_local_port !== e.r.lport)
						report("lport", 32'(out_local_port), 32'(e.r.lport));
					if (out_remote_port !== e.r.rport)
						report("rport", 32'(out_remote_port), 32'(e.r.rport));
					if (seq_out !== e.r.seq) report("seq", seq_out, e.r.seq);
					if (ack_out !== e.r.ack) report("ack", ack_out, e.r.ack);
					if (deliver_length !== e.r.dlen)
						report("dlen", 32'(deliver_length), 32'(e.r.dlen));
					if (last !== e.last) report("last", 32'(last), 32'(e.last));
				end
			end
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("watchdog: no progress, %0d beats outstanding", expected_beats.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic seg_item_t seg(input logic [15:0] lp, input logic [15:0] rp,
			input logic [31:0] sq, input logic [31:0] ak, input logic [7:0] fl,
			input logic [15:0] ln, input logic [31:0] now);
		seg_item_t it;
		it.func = 1'b0;
		it.now = now;
		it.raddr = $urandom();
		it.laddr = $urandom();
		it.rport = rp;
		it.lport = lp;
		it.seq = sq;
		it.ack = ak;
		it.flags = fl;
		it.len = ln;
		it.ok = 1'b1;
		it.listen = 1'b1;
		return it;
	endfunction

	function automatic seg_item_t tick(input logic [31:0] now);
		seg_item_t it;
		it = '0;
		it.func = 1'b1;
		it.now = now;
		return it;
	endfunction

	task automatic settle();
		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_beats.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tpce_pkg::REG_RTO: m_rto0 = val[7:0];
			tpce_pkg::REG_RETRY: m_retry_lim = val[7:0];
			tpce_pkg::REG_CWND: m_cwnd0 = val[15:0];
			tpce_pkg::REG_SSTH: m_ssth0 = val[15:0];
			tpce_pkg::REG_SEED: m_lfsr = val;
			default: ;
		endcase
	endtask

	// queue a handshake, up to three data segments and maybe a close on one port pair
	task automatic queue_flow(input logic [15:0] lp, input logic [15:0] rp,
			input logic [31:0] now);
		logic [31:0] sq, isn;
		logic [15:0] ln;
		sq = $urandom();
		isn = m_lfsr;
		pending_items.push_back(seg(lp, rp, sq, 32'd0, 8'h02, 16'd0, now));
		// the ISN is unknown until predicted, so guess it from a shadow step
		isn = (isn == 32'd0) ? 32'd1 : isn;
		isn = isn[0] ? ((isn >> 1) ^ tpce_pkg::LFSR_MASK) : (isn >> 1);
		pending_items.push_back(seg(lp, rp, sq + 32'd1,
			($urandom_range(3) == 0) ? $urandom() : isn + 32'd1, 8'h10, 16'd0, now + 32'd1));
		sq = sq + 32'd1;
		repeat ($urandom_range(3)) begin
			ln = ($urandom_range(9) == 0) ? 16'(($urandom_range(1) ? 16'hFFFF : $urandom()))
				: 16'($urandom_range(1, 1500));
			pending_items.push_back(seg(lp, rp, ($urandom_range(5) == 0) ? $urandom() : sq,
				$urandom(), 8'h10 | 8'($urandom_range(1) << 3), ln, now + 32'd2));
			sq = sq + 32'(ln);
		end
		if ($urandom_range(1)) begin
			pending_items.push_back(seg(lp, rp, sq, $urandom(), 8'h11, 16'd0, now + 32'd3));
			if ($urandom_range(1))
				pending_items.push_back(seg(lp, rp, sq + 32'd1, $urandom(), 8'h10, 16'd0,
					now + 32'd4));
		end
	endtask

	initial begin
		seg_item_t it;
		logic [31:0] now;
		int sel;
		m_rto0 = 8'd1;
		m_retry_lim = 8'd5;
		m_cwnd0 = 16'd1;
		m_ssth0 = 16'd64;
		m_lfsr = 32'd1;
		for (int i = 0; i < NSLOT; i++) begin
			m_st[i] = tpce_pkg::ST_CLOSED;
			m_slot[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: invalid, unmatched, full handshake, data, FIN, RST, ticks
		it = seg(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'd0);
		it.ok = 1'b0;
		pending_items.push_back(it);
		pending_items.push_back(seg(16'd0, 16'd0, 32'hFFFF_FFFF, 32'd5, 8'h03, 16'hFFFF, 32'd0));
		pending_items.push_back(seg(16'd80, 16'd1, 32'd7, 32'd9, 8'h10, 16'd3, 32'd0));
		it = seg(16'd80, 16'd1, 32'd7, 32'd0, 8'h02, 16'd0, 32'd0);
		it.listen = 1'b0;
		pending_items.push_back(it);
		queue_flow(16'd80, 16'd1000, 32'd0);
		settle();
		pending_items.push_back(seg(16'd81, 16'd2, 32'hFFFF_FFFF, 32'd0, 8'h02, 16'd0,
			32'hFFFF_FFF0));
		pending_items.push_back(seg(16'd81, 16'd2, 32'd0, 32'd0, 8'h02, 16'd0, 32'd0));
		pending_items.push_back(seg(16'd81, 16'd2, 32'd5, 32'd0, 8'h04, 16'd0, 32'd0));
		pending_items.push_back(tick(32'd3));
		pending_items.push_back(tick(32'hFFFF_FFFF));
		pending_items.push_back(seg(16'd81, 16'd2, 32'd0, 32'd0, 8'h04, 16'd0, 32'd0));
		settle();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin send_idle = 60; recv_idle = 32; end
			if (ph == 4) begin send_idle = 0; recv_idle = 0; end
			write_reg(tpce_pkg::REG_RTO, (ph == 0) ? 32'd255 : (ph == 1) ? 32'd1 :
				32'($urandom_range(1, 255)));
			write_reg(tpce_pkg::REG_RETRY, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd255 :
				32'($urandom_range(255)));
			write_reg(tpce_pkg::REG_CWND, (ph == 0) ? 32'd65535 : (ph == 1) ? 32'd1 :
				32'($urandom_range(1, 65535)));
			write_reg(tpce_pkg::REG_SSTH, (ph == 0) ? 32'd1 : (ph == 1) ? 32'd65535 :
				32'($urandom_range(1, 65535)));
			write_reg(tpce_pkg::REG_SEED, (ph == 0) ? 32'hFFFF_FFFF : (ph == 5) ? 32'd0 :
				$urandom() | 32'd1);
			now = $urandom();
			repeat (50) begin
				sel = $urandom_range(99);
				now = now + 32'($urandom_range(0, 300));
				if (sel < 55) queue_flow(16'($urandom_range(20)), 16'($urandom_range(20)), now);
				else if (sel < 75) begin
					pending_items.push_back(tick(now));
					ticks_sent++;
				end else begin
					it = seg(16'($urandom_range(20)), 16'($urandom_range(20)),
						$urandom(), $urandom(), 8'($urandom()), 16'($urandom()), now);
					it.raddr = $urandom();
					it.ok = ($urandom_range(7) != 0);
					it.listen = 1'($urandom_range(1));
					pending_items.push_back(it);
				end
				if (pending_items.size() > 48) break;
			end
			// let everything drain before the next phase
			if (ph == 3) begin
				wait (pending_items.size() == 0 && !in_valid);
				hold_send = 1'b1;
				wait (expected_beats.size() == 0);
				hold_send = 1'b0;
			end
			settle();
		end

		$display("covered %0d items (%0d random ticks), %0d result beats checked",
			items_sent, ticks_sent, beats_seen);
		$display("six register settings, idle mixes on both sides, drain pause");
		if (errors == 0 && expected_beats.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
design/tpce_pkg.sv
design/tcp_passive_connection_engine.sv
test/testbench.sv
